>>> src/spectral_band_peak_picker_defines.svh
// Assertion macros shared by the spectral band peak picker
`ifndef SPECTRAL_BAND_PEAK_PICKER_DEFINES_SVH
`define SPECTRAL_BAND_PEAK_PICKER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define SBPP_ASSERT_NOW(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("sbpp: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define SBPP_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("sbpp: next-cycle check failed");

`endif

>>> src/sbpp_pkg.sv
package sbpp_pkg;

	localparam int unsigned HALF_FRAME_BINS_DEF = 128;
	localparam int unsigned TOP_BANDS_DEF       = 8;
	localparam int unsigned MAX_EMIT            = 8;

	localparam int unsigned MAG_W   = 24;
	localparam int unsigned SUM_W   = 25;
	localparam int unsigned FCNT_W  = 16;
	localparam int unsigned RATIO_W = 16;
	localparam int unsigned KEY_W   = RATIO_W + 1;
	// dividend holds mean*count + sum
	localparam int unsigned DD_W    = SUM_W + FCNT_W + 1;

	// configuration register indexes
	localparam logic [1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_NEEDED    = 2'd1;
	localparam logic [1:0] CFG_SILENCE   = 2'd2;

	typedef enum logic [1:0] {
		KIND_RAINBOW = 2'd0,
		KIND_BLANK   = 2'd1,
		KIND_BAND    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [MAG_W-1:0] left_magnitude;
		logic [MAG_W-1:0] right_magnitude;
		logic             frame_end;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         rank;
		logic [6:0]         bin_number;
		logic [RATIO_W-1:0] ratio;
		logic               slot_valid;
		logic               last_result;
	} out_item_t;

	// control from the sequencer to the ranking table
	typedef struct packed {
		logic clear;
		logic insert;
	} rank_ctl_t;

endpackage

>>> src/sbpp_ram.sv
module sbpp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/sbpp_div.sv
module sbpp_div #(
	parameter int unsigned DD_W = 42,
	parameter int unsigned DS_W = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DD_W-1:0] dividend,
	input  logic [DS_W-1:0] divisor,
	output logic            busy,
	output logic            done,
	output logic [DD_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(DD_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DS_W-1:0]   div_q;
	logic [DS_W-1:0]   rem_q;
	logic [DD_W-1:0]   quo_q;
	logic [DS_W:0]     trial;
	logic              fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[DD_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DS_W'(trial - {1'b0, div_q}) : trial[DS_W-1:0];
			quo_q <= {quo_q[DD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> src/sbpp_rank.sv
module sbpp_rank #(
	parameter int unsigned TOP_BANDS = sbpp_pkg::TOP_BANDS_DEF,
	parameter int unsigned BIN_W     = 7,
	parameter int unsigned IDX_W     = (TOP_BANDS > 1) ? $clog2(TOP_BANDS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbpp_pkg::rank_ctl_t            ctl,
	input  logic [BIN_W-1:0]               ins_bin,
	input  logic [sbpp_pkg::RATIO_W-1:0]   ins_ratio,
	input  logic [IDX_W-1:0]               rd_idx,
	output logic [BIN_W-1:0]               rd_bin,
	output logic [sbpp_pkg::KEY_W-1:0]     rd_key
);

	logic [BIN_W-1:0]            bins_q [TOP_BANDS];
	logic [sbpp_pkg::KEY_W-1:0]  keys_q [TOP_BANDS];
	logic [sbpp_pkg::KEY_W-1:0]  key;
	logic [TOP_BANDS-1:0]        gt;

	// keys carry a valid mark above the ratio; table is sorted descending,
	// so gt is set from the insert position to the end
	assign key = {1'b1, ins_ratio};

	always_comb begin
		for (int j = 0; j < TOP_BANDS; j++) begin
			gt[j] = key > keys_q[j];
		end
	end

	// clear, or insert and shift the lower entries down by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TOP_BANDS; j++) begin
				bins_q[j] <= '0;
				keys_q[j] <= '0;
			end
		end else if (ctl.clear) begin
			for (int j = 0; j < TOP_BANDS; j++) begin
				bins_q[j] <= '0;
				keys_q[j] <= '0;
			end
		end else if (ctl.insert) begin
			for (int j = 0; j < TOP_BANDS; j++) begin
				if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
					bins_q[j] <= bins_q[(j > 0) ? j - 1 : 0];
					keys_q[j] <= keys_q[(j > 0) ? j - 1 : 0];
				end else if (gt[j]) begin
					bins_q[j] <= ins_bin;
					keys_q[j] <= key;
				end
			end
		end
	end

	assign rd_bin = bins_q[rd_idx];
	assign rd_key = keys_q[rd_idx];

endmodule

>>> src/spectral_band_peak_picker.sv
// Spectral band peak picker. Bins of a frame stream in one per cycle with no
// stall, numbered from 1; bins past HALF_FRAME_BINS-1 are dropped but their
// frame end mark still closes the frame. A silent frame yields one rainbow or
// blank item, which waits in the decide state while the result register is
// full and stalled. An active frame then walks every loaded bin through one
// shared restoring divider, after the decide state. Each bin passes a read and
// a multiply state. The mean update runs DD_W = 42 divider steps, then raises
// done. The ratio division follows only when the mean is nonzero. Then come
// min(TOP_BANDS, 8) result items, one per cycle while the output does not
// stall. The divider is the rate limiter; input is stalled throughout. After
// reset the block zeroes all HALF_FRAME_BINS running means before it takes
// its first bin. Configuration writes are always taken.
`include "spectral_band_peak_picker_defines.svh"

module spectral_band_peak_picker #(
	parameter int unsigned HALF_FRAME_BINS = sbpp_pkg::HALF_FRAME_BINS_DEF,
	parameter int unsigned TOP_BANDS       = sbpp_pkg::TOP_BANDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  sbpp_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sbpp_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [sbpp_pkg::MAG_W-1:0] cfg_data
);

	localparam int unsigned BIN_W  = $clog2(HALF_FRAME_BINS);
	localparam int unsigned CNT_W  = $clog2(HALF_FRAME_BINS + 1);
	localparam int unsigned IDX_W  = (TOP_BANDS > 1) ? $clog2(TOP_BANDS) : 1;
	localparam int unsigned EMIT_N = (TOP_BANDS < sbpp_pkg::MAX_EMIT) ?
		TOP_BANDS : sbpp_pkg::MAX_EMIT;
	localparam int unsigned EIDX_W = (EMIT_N > 1) ? $clog2(EMIT_N) : 1;
	localparam int unsigned SUM_W  = sbpp_pkg::SUM_W;
	localparam int unsigned DD_W   = sbpp_pkg::DD_W;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_LOAD   = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_MUL    = 8'b0001_0000,
		ST_DIV1   = 8'b0010_0000,
		ST_DIV2   = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t                     state_q;
	logic [sbpp_pkg::MAG_W-1:0] thresh_q;
	logic [7:0]                 needed_q;
	logic [7:0]                 limit_q;
	logic [CNT_W-1:0]           bin_cnt_q;
	logic [7:0]                 left_cnt_q;
	logic [7:0]                 right_cnt_q;
	logic [7:0]                 silent_q;
	logic [sbpp_pkg::FCNT_W-1:0] frames_q;
	logic [BIN_W-1:0]           clr_idx_q;
	logic [BIN_W-1:0]           bin_idx_q;
	logic [EIDX_W-1:0]          emit_idx_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       out_valid_q;
	sbpp_pkg::out_item_t        out_data_q;

	logic                       in_acc;
	logic                       load_ok;
	logic                       out_free;
	logic                       silent;
	logic [7:0]                 silent_inc;
	logic                       last_bin;

	logic                       sums_we;
	logic [SUM_W-1:0]           sums_rd;
	logic                       means_we;
	logic [BIN_W-1:0]           means_wa;
	logic [SUM_W-1:0]           means_wd;
	logic [SUM_W-1:0]           means_rd;

	logic                       div_start;
	logic [DD_W-1:0]            div_dd;
	logic [SUM_W-1:0]           div_ds;
	logic                       div_busy;
	logic                       div_done;
	logic [DD_W-1:0]            div_quo;
	logic [SUM_W-1:0]           mean;
	logic [sbpp_pkg::RATIO_W-1:0] ratio_sat;

	sbpp_pkg::rank_ctl_t        rk_ctl;
	logic [BIN_W-1:0]           rk_bin;
	logic [sbpp_pkg::KEY_W-1:0] rk_key;

	assign in_stall  = (state_q != ST_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign load_ok   = bin_cnt_q < CNT_W'(HALF_FRAME_BINS);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign silent    = (left_cnt_q < needed_q) && (right_cnt_q < needed_q);
	assign silent_inc = (silent_q == 8'hFF) ? silent_q : silent_q + 8'd1;
	assign last_bin  = (CNT_W'(bin_idx_q) + CNT_W'(1)) == bin_cnt_q;
	assign mean      = div_quo[SUM_W-1:0];
	assign ratio_sat = (|div_quo[DD_W-1:sbpp_pkg::RATIO_W]) ? '1 :
		div_quo[sbpp_pkg::RATIO_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= sbpp_pkg::MAG_W'(3277);
			needed_q <= 8'd32;
			limit_q  <= 8'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sbpp_pkg::CFG_THRESHOLD: thresh_q <= cfg_data;
				sbpp_pkg::CFG_NEEDED:    needed_q <= cfg_data[7:0];
				sbpp_pkg::CFG_SILENCE:   limit_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// frame sums and running means
	assign sums_we  = in_acc && load_ok;
	assign means_we = (state_q == ST_CLEAR) || (state_q == ST_DIV1 && div_done);
	assign means_wa = (state_q == ST_CLEAR) ? clr_idx_q : bin_idx_q;
	assign means_wd = (state_q == ST_CLEAR) ? '0 : mean;

	sbpp_ram #(.WIDTH(SUM_W), .DEPTH(HALF_FRAME_BINS)) u_sums (
		.clk     (clk),
		.wr_en   (sums_we),
		.wr_addr (bin_cnt_q[BIN_W-1:0]),
		.wr_data (SUM_W'(in_data.left_magnitude) + SUM_W'(in_data.right_magnitude)),
		.rd_en   (state_q == ST_READ),
		.rd_addr (bin_idx_q),
		.rd_data (sums_rd)
	);

	sbpp_ram #(.WIDTH(SUM_W), .DEPTH(HALF_FRAME_BINS)) u_means (
		.clk     (clk),
		.wr_en   (means_we),
		.wr_addr (means_wa),
		.wr_data (means_wd),
		.rd_en   (state_q == ST_READ),
		.rd_addr (bin_idx_q),
		.rd_data (means_rd)
	);

	// shared divider: mean update, then ratio
	always_comb begin
		div_start = 1'b0;
		div_dd    = '0;
		div_ds    = '0;
		if (state_q == ST_MUL) begin
			div_start = 1'b1;
			div_dd    = DD_W'(means_rd * frames_q) + DD_W'(sums_rd);
			div_ds    = SUM_W'(frames_q) + SUM_W'(1);
		end else if (state_q == ST_DIV1 && div_done && mean != '0) begin
			div_start = 1'b1;
			div_dd    = DD_W'({sum_q, 8'd0});
			div_ds    = mean;
		end
	end

	sbpp_div #(.DD_W(DD_W), .DS_W(SUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dd),
		.divisor  (div_ds),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ranking table
	assign rk_ctl.clear  = (state_q == ST_DECIDE) && !silent;
	assign rk_ctl.insert = (state_q == ST_DIV2) && div_done;

	sbpp_rank #(.TOP_BANDS(TOP_BANDS), .BIN_W(BIN_W), .IDX_W(IDX_W)) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rk_ctl),
		.ins_bin   (bin_idx_q),
		.ins_ratio (ratio_sat),
		.rd_idx    (IDX_W'(emit_idx_q)),
		.rd_bin    (rk_bin),
		.rd_key    (rk_key)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			bin_cnt_q   <= CNT_W'(1);
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			silent_q    <= '0;
			frames_q    <= '0;
			bin_idx_q   <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == BIN_W'(HALF_FRAME_BINS - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (in_acc) begin
						if (load_ok) begin
							bin_cnt_q <= bin_cnt_q + 1'b1;
							if (in_data.left_magnitude > thresh_q && left_cnt_q != 8'hFF) begin
								left_cnt_q <= left_cnt_q + 8'd1;
							end
							if (in_data.right_magnitude > thresh_q &&
								right_cnt_q != 8'hFF) begin
								right_cnt_q <= right_cnt_q + 8'd1;
							end
						end
						if (in_data.frame_end) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (silent) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							silent_q    <= (silent_inc > limit_q) ? limit_q : silent_inc;
							bin_cnt_q   <= CNT_W'(1);
							left_cnt_q  <= '0;
							right_cnt_q <= '0;
							state_q     <= ST_LOAD;
						end
					end else begin
						silent_q   <= '0;
						bin_idx_q  <= BIN_W'(1);
						emit_idx_q <= '0;
						if (bin_cnt_q > CNT_W'(1)) begin
							state_q <= ST_READ;
						end else begin
							if (frames_q != '1) begin
								frames_q <= frames_q + 1'b1;
							end
							state_q <= ST_EMIT;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIV1;
				end
				ST_DIV1, ST_DIV2: begin
					if (div_done) begin
						if (state_q == ST_DIV1 && mean != '0) begin
							state_q <= ST_DIV2;
						end else if (last_bin) begin
							if (frames_q != '1) begin
								frames_q <= frames_q + 1'b1;
							end
							state_q <= ST_EMIT;
						end else begin
							bin_idx_q <= bin_idx_q + 1'b1;
							state_q   <= ST_READ;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						emit_idx_q  <= emit_idx_q + 1'b1;
						if (emit_idx_q == EIDX_W'(EMIT_N - 1)) begin
							bin_cnt_q   <= CNT_W'(1);
							left_cnt_q  <= '0;
							right_cnt_q <= '0;
							state_q     <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// hold the bin sum while its divisions run
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			sum_q <= sums_rd;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && silent && out_free) begin
			out_data_q.kind        <= (silent_inc > limit_q) ? sbpp_pkg::KIND_BLANK :
				sbpp_pkg::KIND_RAINBOW;
			out_data_q.rank        <= '0;
			out_data_q.bin_number  <= '0;
			out_data_q.ratio       <= '0;
			out_data_q.slot_valid  <= 1'b0;
			out_data_q.last_result <= 1'b1;
		end else if (state_q == ST_EMIT && out_free) begin
			out_data_q.kind        <= sbpp_pkg::KIND_BAND;
			out_data_q.rank        <= 3'(emit_idx_q);
			out_data_q.bin_number  <= rk_key[sbpp_pkg::RATIO_W] ? 7'(rk_bin) : 7'd0;
			out_data_q.ratio       <= rk_key[sbpp_pkg::RATIO_W] ?
				rk_key[sbpp_pkg::RATIO_W-1:0] : '0;
			out_data_q.slot_valid  <= rk_key[sbpp_pkg::RATIO_W];
			out_data_q.last_result <= emit_idx_q == EIDX_W'(EMIT_N - 1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SBPP_ASSERT_NOW(a_div_idle_on_start, clk, arst_n, div_start, !div_busy)
	`SBPP_ASSERT_NOW(a_silent_single, clk, arst_n,
		out_valid && out_data.kind != sbpp_pkg::KIND_BAND,
		out_data.last_result && !out_data.slot_valid)
	`SBPP_ASSERT_NEXT(a_emit_ends_frame, clk, arst_n,
		state_q == ST_EMIT && out_free && emit_idx_q == EIDX_W'(EMIT_N - 1),
		state_q == ST_LOAD && out_valid_q && out_data_q.last_result)

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int NBINS = 128;
	localparam int NRANK = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sbpp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sbpp_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [sbpp_pkg::MAG_W-1:0] cfg_data = '0;

	spectral_band_peak_picker u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [23:0] thr_q;
	logic [7:0] need_q, sil_lim_q;
	logic [24:0] bin_sum [NBINS];
	logic [24:0] bin_mean [NBINS];
	logic [15:0] frame_cnt;
	int bin_idx;
	logic [7:0] left_cnt, right_cnt, quiet_cnt;
	sbpp_pkg::out_item_t band_q[$];
	int errors = 0;
	int n_items = 0, n_frames = 0, n_results = 0;
	bit stall_on = 1'b1;

	// rank the bins of a closed frame, or mark it silent, and queue the expected items
	task automatic close_frame();
		logic [6:0] rb [NRANK];
		logic [16:0] rk [NRANK];
		logic [63:0] mean, q;
		logic [16:0] key;
		sbpp_pkg::out_item_t o;
		sbpp_pkg::kind_t k;
		int j;
		if (left_cnt < need_q && right_cnt < need_q) begin
			k = sbpp_pkg::KIND_RAINBOW;
			if (quiet_cnt < 8'd255) quiet_cnt++;
			if (quiet_cnt > sil_lim_q) begin
				quiet_cnt = sil_lim_q;
				k = sbpp_pkg::KIND_BLANK;
			end
			o = '0;
			o.kind = k;
			o.last_result = 1'b1;
			band_q.push_back(o);
		end else begin
			quiet_cnt = '0;
			for (int r = 0; r < NRANK; r++) begin
				rb[r] = '0;
				rk[r] = '0;
			end
			for (int i = 1; i < bin_idx; i++) begin
				mean = (64'(bin_mean[i]) * frame_cnt + bin_sum[i]) / (64'(frame_cnt) + 1);
				bin_mean[i] = mean[24:0];
				if (mean != 0) begin
					q = (64'(bin_sum[i]) << 8) / mean;
					if (q > 64'hFFFF) q = 64'hFFFF;
					key = {1'b1, q[15:0]};
					j = 0;
					while (j < NRANK && !(key > rk[j])) j++;
					if (j < NRANK) begin
						for (int m = NRANK - 1; m > j; m--) begin
							rb[m] = rb[m-1];
							rk[m] = rk[m-1];
						end
						rb[j] = 7'(i);
						rk[j] = key;
					end
				end
			end
			if (frame_cnt != 16'hFFFF) frame_cnt++;
			for (int r = 0; r < NRANK; r++) begin
				o.kind = sbpp_pkg::KIND_BAND;
				o.rank = 3'(r);
				o.slot_valid = rk[r][16];
				o.bin_number = rk[r][16] ? rb[r] : 7'd0;
				o.ratio = rk[r][16] ? rk[r][15:0] : 16'd0;
				o.last_result = (r == NRANK - 1);
				band_q.push_back(o);
			end
		end
		bin_idx = 1;
		left_cnt = '0;
		right_cnt = '0;
		n_frames++;
	endtask

	// advance the predictor by one accepted bin
	task automatic load_bin(sbpp_pkg::in_item_t it);
		if (bin_idx < NBINS) begin
			bin_sum[bin_idx] = 25'(it.left_magnitude) + 25'(it.right_magnitude);
			if (it.left_magnitude > thr_q && left_cnt != 8'd255) left_cnt++;
			if (it.right_magnitude > thr_q && right_cnt != 8'd255) right_cnt++;
			bin_idx++;
		end
		if (it.frame_end) close_frame();
	endtask

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 30);
		repeat (g) @(posedge clk);
	endtask

	// send one bin, holding it until taken; valid stays up for a following bin
	task automatic send_bin(logic [23:0] l, logic [23:0] r, logic fe, bit gaps);
		sbpp_pkg::in_item_t it;
		it = '{left_magnitude: l, right_magnitude: r, frame_end: fe};
		if (gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
			idle_gap();
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		load_bin(it);
		n_items++;
	endtask

	// drop valid, wait until every expected item is in, then let the divider settle
	task automatic drain();
		in_valid <= 1'b0;
		while (band_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write a register once the block is idle
	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sbpp_pkg::CFG_THRESHOLD: thr_q = val;
			sbpp_pkg::CFG_NEEDED:    need_q = val[7:0];
			sbpp_pkg::CFG_SILENCE:   sil_lim_q = val[7:0];
			default: ;
		endcase
	endtask

	// check each item leaving the block
	always @(posedge clk) begin
		sbpp_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (band_q.size() == 0) begin
				$error("unexpected item %p", out_data);
				errors++;
			end else begin
				e = band_q.pop_front();
				if (out_data.kind != e.kind) begin
					$error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
				end
				if (out_data.rank != e.rank) begin
					$error("rank exp %0d got %0d", e.rank, out_data.rank); errors++;
				end
				if (out_data.bin_number != e.bin_number) begin
					$error("bin_number exp %0d got %0d", e.bin_number,
						out_data.bin_number); errors++;
				end
				if (out_data.ratio != e.ratio) begin
					$error("ratio exp %0d got %0d", e.ratio, out_data.ratio); errors++;
				end
				if (out_data.slot_valid != e.slot_valid) begin
					$error("slot_valid exp %0d got %0d", e.slot_valid,
						out_data.slot_valid); errors++;
				end
				if (out_data.last_result != e.last_result) begin
					$error("last_result exp %0d got %0d", e.last_result,
						out_data.last_result); errors++;
				end
			end
		end
	end

	// random receiver stalls, with quiet stretches
	always @(posedge clk) begin
		if (!stall_on) out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 5) out_stall <= 1'b1;
		else if ($urandom_range(0, 9) < 6) out_stall <= 1'b0;
	end

	// directed: field extremes, tiny frames, overflow bins, zero means, ties
	task automatic test_directed();
		write_reg(sbpp_pkg::CFG_NEEDED, 24'd1);
		send_bin(24'hFFFFFF, 24'hFFFFFF, 1'b0, 0);
		send_bin(24'd0, 24'd0, 1'b0, 0);
		send_bin(24'h000100, 24'h000100, 1'b0, 0);
		send_bin(24'h000100, 24'h000100, 1'b1, 0);
		send_bin(24'h0, 24'h0, 1'b1, 0);
		send_bin(24'hAAAAAA, 24'h555555, 1'b0, 0);
		send_bin(24'h555555, 24'hAAAAAA, 1'b1, 0);
		drain();
		// overfull frame: bins beyond the table are dropped
		for (int i = 0; i < 133; i++)
			send_bin(24'(i * 5000), 24'(($urandom & 24'hFFFFFF)), i == 132, 1);
		drain();
	endtask

	// silent frames run into the limit, including limit zero and max
	task automatic test_silence();
		write_reg(sbpp_pkg::CFG_THRESHOLD, 24'hFFFFFF);
		write_reg(sbpp_pkg::CFG_SILENCE, 24'd0);
		repeat (2) send_bin(24'hFFFFFF, 24'h0, 1'b1, 1);
		write_reg(sbpp_pkg::CFG_SILENCE, 24'd3);
		repeat (5) send_bin(24'($urandom), 24'($urandom), 1'b1, 1);
		drain();
		write_reg(sbpp_pkg::CFG_SILENCE, 24'd255);
		repeat (3) send_bin(24'h0, 24'h0, 1'b1, 1);
		write_reg(sbpp_pkg::CFG_NEEDED, 24'd0);
		send_bin(24'h0, 24'h0, 1'b1, 1);
		drain();
		write_reg(sbpp_pkg::CFG_NEEDED, 24'd255);
		write_reg(sbpp_pkg::CFG_THRESHOLD, 24'd0);
		send_bin(24'h1, 24'h1, 1'b1, 1);
		drain();
	endtask

	// random frames, mostly short and active, some silent and long
	task automatic test_random();
		int len;
		logic [23:0] base;
		write_reg(sbpp_pkg::CFG_THRESHOLD, 24'd3277);
		write_reg(sbpp_pkg::CFG_NEEDED, 24'd2);
		write_reg(sbpp_pkg::CFG_SILENCE, 24'd2);
		while (n_items < 270) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 135)
				: $urandom_range(1, 10);
			if (len > 270 - n_items) len = 270 - n_items;
			stall_on = ($urandom_range(0, 4) != 0);
			base = ($urandom_range(0, 4) == 0) ? 24'd100 : 24'($urandom);
			for (int i = 0; i < len; i++)
				send_bin($urandom_range(0, 3) == 0 ? 24'($urandom) : base >> $urandom_range(0, 8),
					$urandom_range(0, 9) == 0 ? 24'hFFFFFF : 24'($urandom) >> $urandom_range(0, 20),
					i == len - 1, 1);
			if ($urandom_range(0, 7) == 0) begin
				drain();
				write_reg(2'($urandom_range(0, 2)), 24'($urandom_range(0, 4)));
			end
		end
		drain();
		stall_on = 1'b1;
	endtask

	initial begin
		thr_q = 24'd3277;
		need_q = 8'd32;
		sil_lim_q = 8'd50;
		for (int i = 0; i < NBINS; i++) begin
			bin_mean[i] = '0;
			bin_sum[i] = '0;
		end
		frame_cnt = '0;
		quiet_cnt = '0;
		bin_idx = 1;
		left_cnt = '0;
		right_cnt = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_silence();
		test_random();
		repeat (200) @(posedge clk);
		$display("covered %0d bins in %0d frames, %0d result items checked",
			n_items, n_frames, n_results);
		if (errors == 0 && band_q.size() == 0)
			$display("spectral_band_peak_picker test passed");
		else
			$display("spectral_band_peak_picker test failed");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("spectral_band_peak_picker test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/sbpp_pkg.sv
src/sbpp_ram.sv
src/sbpp_div.sv
src/sbpp_rank.sv
src/spectral_band_peak_picker.sv
bench/tb_top.sv
